### sv/sha256_pkg.sv
// Shared types, constants and functions of the SHA-256 hash engine.
package sha256_pkg;

   localparam int BlockBytes = 64;
   localparam int PadLimit = 56;
   localparam logic [7:0] PadMarker = 8'h80;

   typedef logic [255:0] hash_type;

   localparam hash_type InitialHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUNDS,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start_rounds;  // load working vars from hash
      logic round_step;    // run one round
      logic fold;          // add working vars into hash
      logic write_marker;  // write the 0x80 marker byte
      logic pad_fill;      // write one padding byte
      logic pad_zero;      // padding bytes carry no length in this block
      logic clear_msg;     // return to initial values
   } cmd_type;

   typedef struct packed {
      logic       last_round;
      logic [6:0] fill;     // bytes pending in block
   } status_type;

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k [64];
      k = '{
         32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
         32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
         32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
         32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
         32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
         32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
         32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
         32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
         32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
         32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
         32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};
      return k[t];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

endpackage

### sv/sha256_datapath.sv
// Datapath of the SHA-256 engine: block buffer, schedule, round unit and hash.
module sha256_datapath
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_we,
   input  logic [7:0]  byte_data,
   input  cmd_type     cmd,
   output status_type  status,
   output hash_type    hash
);
   localparam int FillW = $clog2(BlockBytes) + 1;
   localparam int IdxW  = $clog2(BlockBytes);

   logic [FillW-1:0]         fill_ff, fill_in;
   logic [60:0]              len_ff, len_in;
   hash_type                 hash_ff, hash_in;
   // The schedule words hold the block bytes while they arrive; input is stalled
   // during the rounds, so the two uses never overlap.
   logic [31:0]              w_ff [16];
   logic [31:0]              v_ff [8];
   logic [5:0]               round_ff;

   logic [31:0] w_cur, s0, s1, w_new, t1, t2, a, e;
   logic [7:0]  pad_byte, wr_byte;
   logic        wr_en;
   logic [63:0] bits;
   logic [IdxW-1:0] widx;
   logic [3:0]  word_sel;
   logic [1:0]  lane_sel;

   assign bits = {len_ff, 3'b000};
   assign widx = fill_ff[IdxW-1:0];
   assign word_sel = widx[IdxW-1:2];
   assign lane_sel = widx[1:0];

   always_comb begin
      pad_byte = 8'h00;
      if (fill_ff >= FillW'(PadLimit) && !cmd.pad_zero) begin
         pad_byte = bits[8*(7 - 32'(widx[2:0])) +: 8];
      end
      wr_en = byte_we || cmd.write_marker || cmd.pad_fill;
      wr_byte = pad_byte;
      if (byte_we) begin
         wr_byte = byte_data;
      end else if (cmd.write_marker) begin
         wr_byte = PadMarker;
      end
   end

   // Round logic.
   always_comb begin
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = s1 + w_ff[9] + s0 + w_ff[0];
      w_cur = (round_ff < 6'd16) ? w_ff[0] : w_new;
      a = v_ff[0];
      e = v_ff[4];
      t1 = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) +
           ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(round_ff) + w_cur;
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) +
           ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_comb begin
      fill_in = fill_ff;
      len_in  = len_ff;
      hash_in = hash_ff;
      if (wr_en) fill_in = fill_ff + FillW'(1);
      if (byte_we) len_in = len_ff + 61'd1;
      if (cmd.start_rounds) fill_in = '0;
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[255-32*i -: 32] = hash_ff[255-32*i -: 32] + v_ff[i];
         end
      end
      if (cmd.clear_msg) begin
         fill_in = '0;
         len_in  = '0;
         hash_in = InitialHash;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         len_ff  <= '0;
         hash_ff <= InitialHash;
      end else begin
         fill_ff <= fill_in;
         len_ff  <= len_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_rounds) begin
         round_ff <= '0;
         for (int i = 0; i < 8; i++) v_ff[i] <= hash_ff[255-32*i -: 32];
      end else if (cmd.round_step) begin
         round_ff <= round_ff + 6'd1;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= a;
         v_ff[0] <= t1 + t2;
      end
      if (wr_en) begin
         w_ff[word_sel][8*(3 - 32'(lane_sel)) +: 8] <= wr_byte;
      end else if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_cur;
      end
   end

   assign status.last_round = (round_ff == 6'd63);
   assign status.fill       = 7'(fill_ff);
   assign hash              = hash_ff;
endmodule

### sv/sha256_control.sv
// Controller state machine of the SHA-256 engine.
module sha256_control
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_word_number,
   output logic        byte_we,
   output cmd_type     cmd,
   input  status_type  status
);
   state_type  state_ff, state_in;
   logic       pad_ff, pad_in;     // padding in progress
   logic       marker_ff, marker_in; // 0x80 not yet written
   logic       extra_ff, extra_in;  // current block is all zeros after the marker
   logic [2:0] word_ff, word_in;
   logic       accept;

   assign accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pad_ff <= 1'b0;
         marker_ff <= 1'b0;
         extra_ff <= 1'b0;
         word_ff <= '0;
      end else begin
         state_ff <= state_in;
         pad_ff <= pad_in;
         marker_ff <= marker_in;
         extra_ff <= extra_in;
         word_ff <= word_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pad_in = pad_ff;
      marker_in = marker_ff;
      extra_in = extra_ff;
      word_in = word_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      byte_we = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (accept) begin
               byte_we = req_byte_present;
               if (req_byte_present && status.fill == 7'(BlockBytes - 1)) begin
                  state_in = ST_LOAD;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
               if (req_end_of_message) begin
                  pad_in = 1'b1;
                  marker_in = 1'b1;
                  extra_in = 1'b0;
               end
            end
         end
         ST_LOAD: begin
            cmd.start_rounds = 1'b1;
            state_in = ST_ROUNDS;
         end
         ST_ROUNDS: begin
            cmd.round_step = 1'b1;
            if (status.last_round) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (marker_ff || extra_ff) begin
               extra_in = 1'b0;
               state_in = ST_PAD;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_PAD: begin
            if (marker_ff) begin
               cmd.write_marker = 1'b1;
               marker_in = 1'b0;
               if (status.fill >= 7'(PadLimit)) extra_in = 1'b1;
            end else begin
               cmd.pad_fill = 1'b1;
               cmd.pad_zero = extra_ff;
            end
            if (status.fill == 7'(BlockBytes - 1)) state_in = ST_LOAD;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  cmd.clear_msg = 1'b1;
                  pad_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_word_number = word_ff;
endmodule

### sv/sha256_hash_engine_top.sv
// Top level of the byte-serial SHA-256 hash engine.
// The engine takes one message byte per input transfer and emits the eight digest
// words, H0 first, as eight result transfers after the transfer that ends the message.
// A byte that does not fill the block is taken without a stall. The 64th byte of a block
// is followed by a load step, the 64 rounds (one round of the shared round unit
// per cycle) and a hash update step.
// The end of a message writes the 0x80 marker, zero bytes and the bit length one byte
// per cycle into the block buffer, then compresses that block. When 56 or more bytes
// were pending, a second block of zeros and the length follows in the same way.
// The digest is then presented one word per cycle when the receiver does not stall.
// Input is stalled during all of this work.
module sha256_hash_engine_top
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_number,
   output logic        rsp_last_word
);
   cmd_type    cmd;
   status_type status;
   hash_type   hash;
   logic       byte_we;

   sha256_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_byte_present, .req_end_of_message,
      .rsp_valid, .rsp_stall, .rsp_word_number, .byte_we, .cmd, .status);

   sha256_datapath u_dp (
      .clock, .reset, .byte_we, .byte_data(req_data_byte), .cmd, .status, .hash);

   assign rsp_digest_word = hash[255 - 32*rsp_word_number -: 32];
   assign rsp_last_word   = (rsp_word_number == 3'd7);
endmodule
